// ----- rtl/timer_table_expiry_assert.svh -----
// Assertion macros used by the timer table module.
`ifndef TIMER_TABLE_EXPIRY_ASSERT_SVH
`define TIMER_TABLE_EXPIRY_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TTE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define TTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tte_pkg.sv -----
package tte_pkg;

  // Table geometry and field widths.
  localparam int TABLE_DEPTH = 16;
  localparam int ID_WIDTH    = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int TIME_W      = 32;
  localparam int STAMP_W     = 16;
  localparam int TIMEOUT_W   = 24;
  localparam int MAX_OUT     = 16;
  localparam int N_W         = $clog2(MAX_OUT + 1);

  // Request codes.
  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  // Result codes.
  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_FOUND     = 3'd2,
    KIND_NOT_FOUND = 3'd3,
    KIND_EXPIRED   = 3'd4,
    KIND_TICK_NONE = 3'd5
  } kind_t;

  // Candidate record handed from cell to cell during a scan.
  typedef struct packed {
    logic                tok;
    logic                found;
    logic [IDX_W-1:0]    idx;
    logic [TIME_W-1:0]   key;
    logic [STAMP_W-1:0]  age;
    logic [ID_WIDTH-1:0] id;
  } cand_t;

  // Scan context broadcast to every cell.
  typedef struct packed {
    req_t                mode;
    logic [TIME_W-1:0]   time_now;
    logic [STAMP_W-1:0]  ins_stamp;
    logic [ID_WIDTH-1:0] cid;
  } ctx_t;

  // Entry write broadcast to every cell.
  typedef struct packed {
    logic                set;
    logic                clr;
    logic [IDX_W-1:0]    idx;
    logic [TIME_W-1:0]   deadline;
    logic [ID_WIDTH-1:0] id;
    logic [STAMP_W-1:0]  stamp;
  } wr_t;

endpackage

// ----- rtl/tte_in_if.sv -----
interface tte_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   req_type;
  logic [tte_pkg::TIMEOUT_W-1:0] timeout;
  logic [15:0]                  timer_id;

  modport source (output valid, req_type, timeout, timer_id, input ready);
  modport sink (input valid, req_type, timeout, timer_id, output ready);
endinterface

// ----- rtl/tte_out_if.sv -----
interface tte_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] result_id;
  logic        last;

  modport source (output valid, kind, result_id, last, input ready);
  modport sink (input valid, kind, result_id, last, output ready);
endinterface

// ----- rtl/tte_cell.sv -----
module tte_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [tte_pkg::IDX_W-1:0] my_idx,
  input  tte_pkg::ctx_t             ctx,
  input  tte_pkg::wr_t              wr,
  input  tte_pkg::cand_t            cand_i,
  output tte_pkg::cand_t            cand_o
);

  logic                          valid_r;
  logic [tte_pkg::TIME_W-1:0]    deadline_r;
  logic [tte_pkg::ID_WIDTH-1:0]  id_r;
  logic [tte_pkg::STAMP_W-1:0]   stamp_r;
  tte_pkg::cand_t                cand_r;
  tte_pkg::cand_t                cand_nxt;
  logic [tte_pkg::TIME_W-1:0]    diff;
  logic [tte_pkg::TIME_W-1:0]    key_me;
  logic [tte_pkg::STAMP_W-1:0]   age_me;
  logic                          due;
  logic                          earlier;
  logic                          sel;

  // Entry storage; only the valid bit needs reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr.idx == my_idx) begin
      if (wr.set) begin
        valid_r <= 1'b1;
      end else if (wr.clr) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.set && wr.idx == my_idx) begin
      deadline_r <= wr.deadline;
      id_r       <= wr.id;
      stamp_r    <= wr.stamp;
    end
  end

  // Wrap-aware ordering key and age of this entry.
  always_comb begin
    diff    = deadline_r - ctx.time_now;
    key_me  = diff ^ {1'b1, {(tte_pkg::TIME_W-1){1'b0}}};
    age_me  = ctx.ins_stamp - stamp_r;
    due     = (diff == '0) || diff[tte_pkg::TIME_W-1];
    earlier = (key_me < cand_i.key) || ((key_me == cand_i.key) && (age_me > cand_i.age));
  end

  // Decide whether this entry replaces the incoming candidate.
  always_comb begin
    case (ctx.mode)
      tte_pkg::REQ_ADD:    sel = !valid_r && !cand_i.found;
      tte_pkg::REQ_CANCEL: sel = valid_r && (id_r == ctx.cid) && (!cand_i.found || earlier);
      tte_pkg::REQ_TICK:   sel = valid_r && due && (!cand_i.found || earlier);
      default:             sel = 1'b0;
    endcase
    cand_nxt = cand_i;
    if (sel) begin
      cand_nxt.found = 1'b1;
      cand_nxt.idx   = my_idx;
      cand_nxt.key   = key_me;
      cand_nxt.age   = age_me;
      cand_nxt.id    = id_r;
    end
  end

  // Hand the candidate to the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= '0;
    end else begin
      cand_r <= cand_nxt;
    end
  end

  assign cand_o = cand_r;

endmodule

// ----- rtl/timer_table_expiry.sv -----
// An add or cancel request passes one scan token through the row of cells, then a decide
// state registers the result and returns to idle; a new request is taken only in idle.
// A tick runs one scan per expired timer plus a closing scan; with sixteen expired the
// closing scan is replaced by a flush state. Output stalls hold the decide and flush states.
// Synchronous reset clears the time, id and stamp counters and every valid bit.
// The deadline, id and stamp fields of the cells are not cleared.
`include "timer_table_expiry_assert.svh"

module timer_table_expiry (
  input  logic      clk,
  input  logic      rst_n,
  tte_in_if.sink    in_ch,
  tte_out_if.source out_ch
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_PASS   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_FLUSH  = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  tte_pkg::req_t                   req_r, req_nxt;
  logic [tte_pkg::TIMEOUT_W-1:0]   timeout_r, timeout_nxt;
  logic [tte_pkg::ID_WIDTH-1:0]    cid_r, cid_nxt;
  logic [tte_pkg::TIME_W-1:0]      time_now_r, time_now_nxt;
  logic [tte_pkg::ID_WIDTH-1:0]    next_id_r, next_id_nxt;
  logic [tte_pkg::STAMP_W-1:0]     ins_stamp_r, ins_stamp_nxt;
  logic                            launch_r, launch_nxt;
  tte_pkg::cand_t                  best_r, best_nxt;
  logic                            pend_v_r, pend_v_nxt;
  logic [tte_pkg::ID_WIDTH-1:0]    pend_id_r, pend_id_nxt;
  logic [tte_pkg::N_W-1:0]         n_r, n_nxt;
  logic                            out_valid_r, out_valid_nxt;
  tte_pkg::kind_t                  out_kind_r, out_kind_nxt;
  logic [tte_pkg::ID_WIDTH-1:0]    out_id_r, out_id_nxt;
  logic                            out_last_r, out_last_nxt;
  logic [tte_pkg::ID_WIDTH-1:0]    nid;
  logic                            out_free;
  logic                            accept;
  tte_pkg::wr_t                    wr;
  tte_pkg::ctx_t                   ctx;
  tte_pkg::cand_t                  chain [tte_pkg::TABLE_DEPTH+1];

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Scan context and the empty candidate that enters the row.
  always_comb begin
    ctx.mode      = req_r;
    ctx.time_now  = time_now_r;
    ctx.ins_stamp = ins_stamp_r;
    ctx.cid       = cid_r;
    chain[0]      = '0;
    chain[0].tok  = launch_r;
  end

  // The row of cells.
  for (genvar g = 0; g < tte_pkg::TABLE_DEPTH; g++) begin : g_cell
    tte_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .my_idx (tte_pkg::IDX_W'(g)),
      .ctx    (ctx),
      .wr     (wr),
      .cand_i (chain[g]),
      .cand_o (chain[g+1])
    );
  end

  // Next id skips zero on wrap.
  always_comb begin
    nid = next_id_r + 1'b1;
    if (nid == '0) begin
      nid = {{(tte_pkg::ID_WIDTH-1){1'b0}}, 1'b1};
    end
  end

  // Request sequencer.
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    timeout_nxt   = timeout_r;
    cid_nxt       = cid_r;
    time_now_nxt  = time_now_r;
    next_id_nxt   = next_id_r;
    ins_stamp_nxt = ins_stamp_r;
    launch_nxt    = 1'b0;
    best_nxt      = best_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;
    wr            = '0;
    wr.idx        = best_r.idx;
    wr.deadline   = time_now_r + {{(tte_pkg::TIME_W-tte_pkg::TIMEOUT_W){1'b0}}, timeout_r};
    wr.id         = nid;
    wr.stamp      = ins_stamp_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt     = tte_pkg::req_t'(in_ch.req_type);
          timeout_nxt = in_ch.timeout;
          cid_nxt     = in_ch.timer_id;
          pend_v_nxt  = 1'b0;
          n_nxt       = '0;
          if (in_ch.req_type != tte_pkg::REQ_NONE) begin
            state_nxt  = S_PASS;
            launch_nxt = 1'b1;
          end
          if (in_ch.req_type == tte_pkg::REQ_TICK) begin
            time_now_nxt = time_now_r + 1'b1;
          end
        end
      end

      S_PASS: begin
        if (chain[tte_pkg::TABLE_DEPTH].tok) begin
          best_nxt  = chain[tte_pkg::TABLE_DEPTH];
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (out_free) begin
          case (req_r)
            tte_pkg::REQ_ADD: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              state_nxt     = S_IDLE;
              if (best_r.found) begin
                wr.set        = 1'b1;
                next_id_nxt   = nid;
                ins_stamp_nxt = ins_stamp_r + 1'b1;
                out_kind_nxt  = tte_pkg::KIND_ADDED;
                out_id_nxt    = nid;
              end else begin
                out_kind_nxt  = tte_pkg::KIND_FULL;
                out_id_nxt    = '0;
              end
            end
            tte_pkg::REQ_CANCEL: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              state_nxt     = S_IDLE;
              if (best_r.found) begin
                wr.clr       = 1'b1;
                out_kind_nxt = tte_pkg::KIND_FOUND;
                out_id_nxt   = cid_r;
              end else begin
                out_kind_nxt = tte_pkg::KIND_NOT_FOUND;
                out_id_nxt   = '0;
              end
            end
            tte_pkg::REQ_TICK: begin
              if (best_r.found) begin
                // Hold this timer back until the next scan, or the flush at the limit, tells whether it is the last.
                wr.clr = 1'b1;
                if (pend_v_r) begin
                  out_valid_nxt = 1'b1;
                  out_kind_nxt  = tte_pkg::KIND_EXPIRED;
                  out_id_nxt    = pend_id_r;
                  out_last_nxt  = 1'b0;
                end
                pend_v_nxt  = 1'b1;
                pend_id_nxt = best_r.id;
                n_nxt       = n_r + 1'b1;
                if (n_r + 1'b1 == tte_pkg::N_W'(tte_pkg::MAX_OUT)) begin
                  state_nxt = S_FLUSH;
                end else begin
                  state_nxt  = S_PASS;
                  launch_nxt = 1'b1;
                end
              end else begin
                out_valid_nxt = 1'b1;
                out_last_nxt  = 1'b1;
                state_nxt     = S_IDLE;
                if (pend_v_r) begin
                  out_kind_nxt = tte_pkg::KIND_EXPIRED;
                  out_id_nxt   = pend_id_r;
                end else begin
                  out_kind_nxt = tte_pkg::KIND_TICK_NONE;
                  out_id_nxt   = '0;
                end
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = tte_pkg::KIND_EXPIRED;
          out_id_nxt    = pend_id_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      time_now_r  <= '0;
      next_id_r   <= '0;
      ins_stamp_r <= '0;
      launch_r    <= 1'b0;
      pend_v_r    <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      time_now_r  <= time_now_nxt;
      next_id_r   <= next_id_nxt;
      ins_stamp_r <= ins_stamp_nxt;
      launch_r    <= launch_nxt;
      pend_v_r    <= pend_v_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    timeout_r  <= timeout_nxt;
    cid_r      <= cid_nxt;
    best_r     <= best_nxt;
    pend_id_r  <= pend_id_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = out_kind_r;
  assign out_ch.result_id = out_id_r;
  assign out_ch.last      = out_last_r;

  // A tick request advances the time by exactly one.
  `TTE_ASSERT_NEXT(a_tick_time, accept && in_ch.req_type == tte_pkg::REQ_TICK, time_now_r == $past(time_now_r) + 1'b1, "tick did not advance time")
  // An assigned id is never zero.
  `TTE_ASSERT_NOW(a_id_nonzero, out_valid_r && out_kind_r == tte_pkg::KIND_ADDED, out_id_r != '0, "zero id assigned")
  // No more timers are taken per tick than the result limit.
  `TTE_ASSERT_NOW(a_count_cap, state_r != S_IDLE, n_r <= tte_pkg::N_W'(tte_pkg::MAX_OUT), "expiry count over limit")
  // A tick with nothing due is always the final result.
  `TTE_ASSERT_NOW(a_none_last, out_valid_r && out_kind_r == tte_pkg::KIND_TICK_NONE, out_last_r, "tick none not last")

endmodule
